// ===== rtl/ias_pkg.sv =====
// ias_pkg: shared types, codes and reset values for the incline actuator supervisor
// no dependencies; imported by every module of the block
package ias_pkg;

    localparam int unsigned RATE_W     = 10;
    localparam int unsigned BAND_W     = 16;
    localparam int unsigned POS_W      = 18;
    localparam int unsigned MS16_W     = 16;
    localparam int unsigned ELAPSED_W  = 10;
    localparam int unsigned TARGET_W   = 19;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 18;

    localparam logic [RATE_W-1:0] RATE_RESET     = 10'd15;
    localparam logic [BAND_W-1:0] DEADBAND_RESET = 16'd1000;
    localparam logic [POS_W-1:0]  MAX_INC_RESET  = 18'd150000;
    localparam logic [MS16_W-1:0] WDOG_RESET     = 16'd1000;
    localparam logic [MS16_W-1:0] WAX_RESET      = 16'd5000;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_UP      = 2'd1,
        MODE_DOWN    = 2'd2,
        MODE_HOMING  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SYNC      = 2'd1,
        OP_CALIBRATE = 2'd2,
        OP_OTHER     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE     = 3'd0,
        REG_DEADBAND = 3'd1,
        REG_MAX_INC  = 3'd2,
        REG_WDOG     = 3'd3,
        REG_WAX      = 3'd4
    } reg_idx_t;

    localparam logic [2:0] FAN_OFF    = 3'd0;
    localparam logic [2:0] FAN_NORMAL = 3'd1;
    localparam logic [2:0] FAN_STRONG = 3'd2;
    localparam logic [1:0] WAX_START  = 2'd1;

    typedef struct packed {
        logic [RATE_W-1:0] rate_per_ms;
        logic [BAND_W-1:0] deadband;
        logic [POS_W-1:0]  max_incline;
        logic [MS16_W-1:0] watchdog_timeout_ms;
        logic [MS16_W-1:0] wax_duration_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                  operation;
        logic [ELAPSED_W-1:0]        elapsed_ms;
        logic signed [TARGET_W-1:0]  incline_target;
        logic [2:0]                  head_fan_level;
        logic [2:0]                  chest_fan_level;
        logic [1:0]                  wax_request;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  target;
        mode_t             mode;
        logic              calibrated;
        logic              emergency;
        logic              direction_down;
        logic [MS16_W-1:0] silence_ms;
        logic [MS16_W-1:0] wax_remaining_ms;
        logic              wax_on;
        logic [1:0]        head_level;
        logic              head_strong;
        logic [1:0]        chest_level;
        logic              act_on;
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] incline_position;
        logic [1:0]       motor_mode;
        logic             is_calibrated;
        logic             in_emergency;
        logic             actuator_on;
        logic             actuator_down;
        logic             head_fan_on;
        logic             head_fan_strong;
        logic             chest_fan_on;
        logic             chest_fan_strong;
        logic             wax_pump_on;
        logic             data_reply;
    } result_t;

endpackage

// ===== rtl/ias_cfg_regs.sv =====
// ias_cfg_regs: configuration register bank with write port
// depends on ias_pkg
module ias_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ias_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ias_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output ias_pkg::cfg_t                     cfg
);
    import ias_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_RATE:     cfg_next.rate_per_ms         = cfg_wdata[RATE_W-1:0];
                REG_DEADBAND: cfg_next.deadband            = cfg_wdata[BAND_W-1:0];
                REG_MAX_INC:  cfg_next.max_incline         = cfg_wdata[POS_W-1:0];
                REG_WDOG:     cfg_next.watchdog_timeout_ms = cfg_wdata[MS16_W-1:0];
                REG_WAX:      cfg_next.wax_duration_ms     = cfg_wdata[MS16_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_per_ms         <= RATE_RESET;
            cfg_reg.deadband            <= DEADBAND_RESET;
            cfg_reg.max_incline         <= MAX_INC_RESET;
            cfg_reg.watchdog_timeout_ms <= WDOG_RESET;
            cfg_reg.wax_duration_ms     <= WAX_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ias_step.sv =====
// ias_step: next-state and result logic for one beat
// depends on ias_pkg
module ias_step (
    input  ias_pkg::cfg_t    cfg,
    input  ias_pkg::state_t  state,
    input  ias_pkg::item_t   item,
    output ias_pkg::state_t  state_next,
    output ias_pkg::result_t result
);
    import ias_pkg::*;

    always_comb begin
        logic [19:0]        delta;
        logic signed [21:0] p_ext;
        logic signed [21:0] t_ext;
        logic signed [21:0] p_up;
        logic signed [21:0] p_dn;
        logic signed [18:0] err;
        logic [18:0]        err_mag;
        logic               big_err;
        logic [16:0]        sil_sum;
        logic               tgt_ok;
        logic               reply;
        state_t             st;

        st    = state;
        reply = 1'b0;

        delta   = 20'(item.elapsed_ms) * 20'(cfg.rate_per_ms);
        p_ext   = signed'({4'b0, state.position});
        t_ext   = signed'({4'b0, state.target});
        p_up    = p_ext + signed'({2'b0, delta});
        p_dn    = p_ext - signed'({2'b0, delta});
        err     = signed'({1'b0, state.target}) - signed'({1'b0, state.position});
        err_mag = err[18] ? 19'(-err) : 19'(err);
        big_err = err_mag > {3'b0, cfg.deadband};
        sil_sum = {1'b0, state.silence_ms} + 17'(item.elapsed_ms);
        tgt_ok  = !item.incline_target[TARGET_W-1]
                  && (item.incline_target[POS_W-1:0] <= cfg.max_incline);

        case (op_t'(item.operation))
            OP_TICK: begin
                if (!state.emergency) begin
                    case (state.mode)
                        MODE_STOPPED: begin
                            if (!state.calibrated) begin
                                st.mode = MODE_HOMING;
                            end else if (big_err) begin
                                st.mode           = err[18] ? MODE_DOWN : MODE_UP;
                                st.direction_down = err[18];
                                st.act_on         = 1'b1;
                            end
                        end
                        MODE_HOMING: begin
                            st.mode       = MODE_STOPPED;
                            st.act_on     = 1'b0;
                            st.position   = '0;
                            st.target     = '0;
                            st.calibrated = 1'b1;
                        end
                        MODE_UP: begin
                            if (p_up >= t_ext) begin
                                st.mode     = MODE_STOPPED;
                                st.act_on   = 1'b0;
                                st.position = state.target;
                            end else begin
                                st.position = p_up[POS_W-1:0];
                            end
                        end
                        default: begin
                            if (p_dn <= t_ext) begin
                                st.mode     = MODE_STOPPED;
                                st.act_on   = 1'b0;
                                st.position = state.target;
                            end else begin
                                st.position = p_dn[POS_W-1:0];
                            end
                        end
                    endcase
                end
                // wax countdown
                if (state.wax_on) begin
                    if (16'(item.elapsed_ms) >= state.wax_remaining_ms) begin
                        st.wax_on           = 1'b0;
                        st.wax_remaining_ms = '0;
                    end else begin
                        st.wax_remaining_ms = state.wax_remaining_ms - 16'(item.elapsed_ms);
                    end
                end
                // watchdog
                st.silence_ms = sil_sum[16] ? '1 : sil_sum[15:0];
                if (!state.emergency && (st.silence_ms > cfg.watchdog_timeout_ms)) begin
                    st.emergency        = 1'b1;
                    st.target           = '0;
                    st.head_level       = '0;
                    st.head_strong      = 1'b0;
                    st.chest_level      = '0;
                    st.wax_on           = 1'b0;
                    st.wax_remaining_ms = '0;
                    st.act_on           = 1'b0;
                    st.mode             = MODE_STOPPED;
                end
            end
            OP_SYNC: begin
                st.emergency  = 1'b0;
                st.silence_ms = '0;
                if (state.calibrated && tgt_ok) begin
                    st.target = item.incline_target[POS_W-1:0];
                end
                if (item.head_fan_level <= FAN_STRONG) begin
                    st.head_level = item.head_fan_level[1:0];
                    if (item.head_fan_level == FAN_NORMAL) begin
                        st.head_strong = 1'b0;
                    end
                    if (item.head_fan_level == FAN_STRONG) begin
                        st.head_strong = 1'b1;
                    end
                end
                if (item.chest_fan_level <= FAN_STRONG) begin
                    st.chest_level = item.chest_fan_level[1:0];
                end
                if ((item.wax_request == WAX_START) && !state.wax_on) begin
                    st.wax_on           = 1'b1;
                    st.wax_remaining_ms = cfg.wax_duration_ms;
                end
                reply = 1'b1;
            end
            OP_CALIBRATE: begin
                st.emergency  = 1'b0;
                st.silence_ms = '0;
                st.mode       = MODE_HOMING;
                st.calibrated = 1'b0;
                reply         = 1'b1;
            end
            default: begin
                st.emergency  = 1'b0;
                st.silence_ms = '0;
            end
        endcase

        state_next = st;

        result.incline_position = st.position;
        result.motor_mode       = st.mode;
        result.is_calibrated    = st.calibrated;
        result.in_emergency     = st.emergency;
        result.actuator_on      = st.act_on;
        result.actuator_down    = st.direction_down;
        result.head_fan_on      = (st.head_level != 2'd0);
        result.head_fan_strong  = st.head_strong;
        result.chest_fan_on     = (st.chest_level != 2'd0);
        result.chest_fan_strong = (st.chest_level == FAN_STRONG[1:0]);
        result.wax_pump_on      = st.wax_on;
        result.data_reply       = reply;
    end

endmodule

// ===== rtl/incline_actuator_supervisor.sv =====
// incline_actuator_supervisor: top level, input register, supervisor state, result register
// depends on ias_pkg, ias_cfg_regs, ias_step
//
//  channel   ports                         beat
//  s_        s_valid/s_ready + 6 fields    one tick or decoded command
//  m_        m_valid/m_ready + 12 fields   one status result per input beat
//  cfg_      cfg_we/cfg_index/cfg_wdata    register write, no wait, no read-back
//
// one beat enters per cycle while the output is not held; a beat waits in the input
// register and moves on to the result register when the result register is free or taken
// state and the result are written at the same edge, from the step logic
// reset puts the machine in homing, uncalibrated, with all relays off
// a held result stalls the input register, which still takes one beat
module incline_actuator_supervisor (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_operation,
    input  logic [ias_pkg::ELAPSED_W-1:0]          s_elapsed_ms,
    input  logic signed [ias_pkg::TARGET_W-1:0]    s_incline_target,
    input  logic [2:0]                             s_head_fan_level,
    input  logic [2:0]                             s_chest_fan_level,
    input  logic [1:0]                             s_wax_request,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ias_pkg::POS_W-1:0]              m_incline_position,
    output logic [1:0]                             m_motor_mode,
    output logic                                   m_is_calibrated,
    output logic                                   m_in_emergency,
    output logic                                   m_actuator_on,
    output logic                                   m_actuator_down,
    output logic                                   m_head_fan_on,
    output logic                                   m_head_fan_strong,
    output logic                                   m_chest_fan_on,
    output logic                                   m_chest_fan_strong,
    output logic                                   m_wax_pump_on,
    output logic                                   m_data_reply,
    input  logic                                   cfg_we,
    input  logic [ias_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ias_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
    import ias_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    m_valid_reg;
    logic    m_valid_next;
    logic    out_free;
    logic    step_fire;
    logic    s_fire;

    ias_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ias_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign step_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (step_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg              <= 1'b0;
            m_valid_reg               <= 1'b0;
            state_reg.position        <= '0;
            state_reg.target          <= '0;
            state_reg.mode            <= MODE_HOMING;
            state_reg.calibrated      <= 1'b0;
            state_reg.emergency       <= 1'b0;
            state_reg.direction_down  <= 1'b0;
            state_reg.silence_ms      <= '0;
            state_reg.wax_remaining_ms <= '0;
            state_reg.wax_on          <= 1'b0;
            state_reg.head_level      <= '0;
            state_reg.head_strong     <= 1'b0;
            state_reg.chest_level     <= '0;
            state_reg.act_on          <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (step_fire) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.operation       <= s_operation;
            in_item_reg.elapsed_ms      <= s_elapsed_ms;
            in_item_reg.incline_target  <= s_incline_target;
            in_item_reg.head_fan_level  <= s_head_fan_level;
            in_item_reg.chest_fan_level <= s_chest_fan_level;
            in_item_reg.wax_request     <= s_wax_request;
        end
        if (step_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_incline_position = res_reg.incline_position;
    assign m_motor_mode       = res_reg.motor_mode;
    assign m_is_calibrated    = res_reg.is_calibrated;
    assign m_in_emergency     = res_reg.in_emergency;
    assign m_actuator_on      = res_reg.actuator_on;
    assign m_actuator_down    = res_reg.actuator_down;
    assign m_head_fan_on      = res_reg.head_fan_on;
    assign m_head_fan_strong  = res_reg.head_fan_strong;
    assign m_chest_fan_on     = res_reg.chest_fan_on;
    assign m_chest_fan_strong = res_reg.chest_fan_strong;
    assign m_wax_pump_on      = res_reg.wax_pump_on;
    assign m_data_reply       = res_reg.data_reply;

endmodule
